// ===== hdl/homography_inlier_check_core_assert.svh =====
// Assertion macros shared by the checker of the inlier test core.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef HOMOGRAPHY_INLIER_CHECK_CORE_ASSERT_SVH
`define HOMOGRAPHY_INLIER_CHECK_CORE_ASSERT_SVH

// check outside reset
`define HIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define HIC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hic_pkg.sv =====
// Shared widths, constants, register indexes and control types of the inlier test core.
// No dependencies.
package hic_pkg;

  localparam int unsigned PT_W        = 24;
  localparam int unsigned COEF_W      = 32;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam int unsigned PROD_W      = COEF_W + PT_W;
  localparam int unsigned ACC_W       = PROD_W + 1;
  localparam int unsigned MAG_W       = PROD_W;
  localparam int unsigned TRANS_SHIFT = 16;
  localparam int unsigned DEN_SHIFT   = 38;

  localparam int unsigned SAT_SHIFT   = 26;
  localparam int unsigned DIV_TAIL    = 15;
  localparam int unsigned DIV_STEPS   = SAT_SHIFT + DIV_TAIL;
  localparam int unsigned DCNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned QMAG_W      = DIV_STEPS;
  localparam int unsigned PROJ_W      = QMAG_W + 1;
  localparam int unsigned DIFF_W      = PROJ_W + 1;
  localparam int unsigned SQ_IN_W     = 25;
  localparam int unsigned SQ_W        = 48;

  localparam int unsigned CNT_W         = 13;
  localparam int unsigned MAX_POINTS    = 4096;
  localparam int unsigned CNT_FIELD_MAX = 2 ** CNT_W - 1;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_POINTS > CNT_FIELD_MAX) ? CNT_FIELD_MAX : MAX_POINTS);

  localparam logic [SQ_W-1:0]   ERR_MAX = '1;
  localparam logic [QMAG_W-1:0] QCAP    = {1'b1, {(QMAG_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  DEN_ONE =
    {{(ACC_W-DEN_SHIFT-1){1'b0}}, 1'b1, {DEN_SHIFT{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H00   = 4'd0,
    REG_H01   = 4'd1,
    REG_H02   = 4'd2,
    REG_H10   = 4'd3,
    REG_H11   = 4'd4,
    REG_H12   = 4'd5,
    REG_PERSP = 4'd6,
    REG_THR   = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROW_DEN = 2'd0,
    ROW_NX  = 2'd1,
    ROW_NY  = 2'd2
  } row_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] h00;
    logic signed [COEF_W-1:0] h01;
    logic signed [COEF_W-1:0] h02;
    logic signed [COEF_W-1:0] h10;
    logic signed [COEF_W-1:0] h11;
    logic signed [COEF_W-1:0] h12;
    logic signed [COEF_W-1:0] h20;
    logic signed [COEF_W-1:0] h21;
    logic        [THR_W-1:0]  thr;
  } coef_t;

  typedef struct packed {
    logic load;
    logic mul;
    row_t mul_row;
    logic div_start;
    logic div_step;
    logic round;
    logic diff;
    logic square;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/homography_inlier_check_core.sv =====
// Homography reprojection-error inlier test, top level.
// Depends on hic_pkg, hic_cfg_regs, hic_ctrl, hic_datapath.
//
// Input channel (in_valid / in_stall): one word per point correspondence,
// source and destination point in signed Q16.8 plus last_point.
// Output channel (out_valid / out_stall): one word per input word with the
// squared error (Q32.16), inlier, degenerate, inlier_total and last_result.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// write only while no word is in flight. Indexes beyond 7 are dropped.
// A word is taken, the three rows are multiplied and summed, the 41-step
// restoring division of the two projected coordinates runs side by side,
// then rounding, difference, squares and sum; then the result is registered.
// A zero perspective denominator skips the division and error steps. One
// word is worked on at a time, the next once its result is registered.
// A result waiting under out_stall does not block the next input word; the
// block holds in its last step until the output register is free.
// MAX_POINTS sets where inlier_total saturates, at most 8191.
// Reset (rst, synchronous) restores the default homography and threshold,
// clears the inlier count and drops any word in flight.
module homography_inlier_check_core #(
  parameter int unsigned MAX_POINTS = hic_pkg::MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hic_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hic_pkg::PT_W-1:0]   src_x,
  input  logic signed [hic_pkg::PT_W-1:0]   src_y,
  input  logic signed [hic_pkg::PT_W-1:0]   dst_x,
  input  logic signed [hic_pkg::PT_W-1:0]   dst_y,
  input  logic                              last_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hic_pkg::SQ_W-1:0]          sq_error,
  output logic                              inlier,
  output logic                              degenerate,
  output logic [hic_pkg::CNT_W-1:0]         inlier_total,
  output logic                              last_result
);

  hic_pkg::coef_t   coef;
  hic_pkg::cmd_t    cmd;
  hic_pkg::status_t status;

  hic_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  hic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hic_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .coef         (coef),
    .src_x        (src_x),
    .src_y        (src_y),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .last_point   (last_point),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sq_error     (sq_error),
    .inlier       (inlier),
    .degenerate   (degenerate),
    .inlier_total (inlier_total),
    .last_result  (last_result)
  );

endmodule

// ===== hdl/hic_cfg_regs.sv =====
// Configuration register file of the inlier test core: homography and threshold.
// Depends on hic_pkg.
module hic_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hic_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hic_pkg::coef_t                   coef
);

  localparam int unsigned CW = hic_pkg::COEF_W;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.h00 <= CW'(32'sd16777216);
      coef.h01 <= '0;
      coef.h02 <= '0;
      coef.h10 <= '0;
      coef.h11 <= CW'(32'sd16777216);
      coef.h12 <= '0;
      coef.h20 <= '0;
      coef.h21 <= '0;
      coef.thr <= hic_pkg::THR_W'(768);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hic_pkg::REG_H00:   coef.h00 <= cfg_data[CW-1:0];
        hic_pkg::REG_H01:   coef.h01 <= cfg_data[CW-1:0];
        hic_pkg::REG_H02:   coef.h02 <= cfg_data[CW-1:0];
        hic_pkg::REG_H10:   coef.h10 <= cfg_data[CW-1:0];
        hic_pkg::REG_H11:   coef.h11 <= cfg_data[CW-1:0];
        hic_pkg::REG_H12:   coef.h12 <= cfg_data[CW-1:0];
        hic_pkg::REG_PERSP: begin
          coef.h20 <= cfg_data[2*CW-1:CW];
          coef.h21 <= cfg_data[CW-1:0];
        end
        hic_pkg::REG_THR:   coef.thr <= cfg_data[hic_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/hic_divider.sv =====
// Restoring divider, one quotient bit per step: rounded |num| * 2^14 / |den|, capped at 2^40.
// Depends on hic_pkg.
module hic_divider (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [hic_pkg::MAG_W-1:0]     num,
  input  logic [hic_pkg::MAG_W-1:0]     den,
  output logic [hic_pkg::QMAG_W-1:0]    quot_mag
);

  localparam int unsigned MW = hic_pkg::MAG_W;
  localparam int unsigned SS = hic_pkg::SAT_SHIFT;
  localparam int unsigned NS = hic_pkg::DIV_STEPS;
  localparam int unsigned QW = hic_pkg::QMAG_W;

  logic [MW-1:0] rem;
  logic [MW-1:0] den_r;
  logic [NS-1:0] tail;
  logic [QW-1:0] quot;
  logic          sat;

  logic [MW+SS-1:0] num_ext;
  logic [MW+SS-1:0] den_sh;
  logic [MW:0]      rem_sh;
  logic [MW:0]      rem_sub;
  logic             fits;
  logic [QW:0]      quot_inc;

  assign num_ext  = {{SS{1'b0}}, num};
  assign den_sh   = {den, {SS{1'b0}}};
  assign rem_sh   = {rem, tail[NS-1]};
  assign rem_sub  = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign quot_inc = {1'b0, quot} + (QW+1)'(1);
  assign quot_mag = sat ? hic_pkg::QCAP : quot_inc[QW:1];

  always_ff @(posedge clk) begin
    if (start) begin
      sat   <= num_ext >= den_sh;
      rem   <= {{SS{1'b0}}, num[MW-1:SS]};
      tail  <= {num[SS-1:0], {hic_pkg::DIV_TAIL{1'b0}}};
      quot  <= '0;
      den_r <= den;
    end else if (step) begin
      rem  <= fits ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
      tail <= {tail[NS-2:0], 1'b0};
      quot <= {quot[QW-2:0], fits};
    end
  end

endmodule

// ===== hdl/hic_datapath.sv =====
// Datapath of the inlier test core: products, projection dividers, error, count, output word.
// Depends on hic_pkg and hic_divider.
module hic_datapath #(
  parameter int unsigned MAX_POINTS = hic_pkg::MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hic_pkg::cmd_t                      cmd,
  output hic_pkg::status_t                   status,
  input  hic_pkg::coef_t                     coef,
  input  logic signed [hic_pkg::PT_W-1:0]    src_x,
  input  logic signed [hic_pkg::PT_W-1:0]    src_y,
  input  logic signed [hic_pkg::PT_W-1:0]    dst_x,
  input  logic signed [hic_pkg::PT_W-1:0]    dst_y,
  input  logic                               last_point,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [hic_pkg::SQ_W-1:0]           sq_error,
  output logic                               inlier,
  output logic                               degenerate,
  output logic [hic_pkg::CNT_W-1:0]          inlier_total,
  output logic                               last_result
);

  localparam int unsigned PW = hic_pkg::PT_W;
  localparam int unsigned CW = hic_pkg::COEF_W;
  localparam int unsigned MW = hic_pkg::PROD_W;
  localparam int unsigned AW = hic_pkg::ACC_W;
  localparam int unsigned GW = hic_pkg::MAG_W;
  localparam int unsigned QW = hic_pkg::QMAG_W;
  localparam int unsigned JW = hic_pkg::PROJ_W;
  localparam int unsigned DW = hic_pkg::DIFF_W;
  localparam int unsigned SW = hic_pkg::SQ_IN_W;
  localparam int unsigned EW = hic_pkg::SQ_W;
  localparam int unsigned TW = hic_pkg::THR_W;
  localparam int unsigned NW = hic_pkg::CNT_W;

  localparam logic [NW-1:0] CNT_CAP =
    NW'((MAX_POINTS > hic_pkg::CNT_FIELD_MAX) ? hic_pkg::CNT_FIELD_MAX : MAX_POINTS);

  logic signed [PW-1:0] sx_r, sy_r, dstx_r, dsty_r;
  logic                 last_r;

  logic signed [CW-1:0] coef_a, coef_b;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] prod_a, prod_b;
  hic_pkg::row_t        prow;
  logic                 pvld;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] row_sum;
  logic signed [AW-1:0] den_acc, nx_acc, ny_acc;

  logic [AW-1:0] den_abs, nx_abs, ny_abs;
  logic          negx, negy, degen_r;
  logic [QW-1:0] qx, qy;

  logic signed [JW-1:0] px_r, py_r;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic [SW-1:0]        ax_r, ay_r;
  logic                 rng_r;
  logic [2*SW-1:0]      sqx_r, sqy_r;
  logic [2*TW-1:0]      thr2_r;
  logic [2*SW:0]        ssum;
  logic [EW-1:0]        sq_r;

  logic          inl;
  logic [NW:0]   total;
  logic [NW-1:0] total_cap;
  logic [NW-1:0] running;

  assign status.w_zero   = den_acc == '0;
  assign status.out_free = !out_valid || !out_stall;

  // coefficient pair and constant term of each row
  always_comb begin
    unique case (cmd.mul_row)
      hic_pkg::ROW_NX: begin
        coef_a = coef.h00;
        coef_b = coef.h01;
      end
      hic_pkg::ROW_NY: begin
        coef_a = coef.h10;
        coef_b = coef.h11;
      end
      default: begin
        coef_a = coef.h20;
        coef_b = coef.h21;
      end
    endcase
  end

  always_comb begin
    unique case (prow)
      hic_pkg::ROW_NX:
        addend = {{(AW-CW-hic_pkg::TRANS_SHIFT){coef.h02[CW-1]}}, coef.h02,
                  {hic_pkg::TRANS_SHIFT{1'b0}}};
      hic_pkg::ROW_NY:
        addend = {{(AW-CW-hic_pkg::TRANS_SHIFT){coef.h12[CW-1]}}, coef.h12,
                  {hic_pkg::TRANS_SHIFT{1'b0}}};
      default:
        addend = hic_pkg::DEN_ONE;
    endcase
  end

  assign mul_a   = coef_a * sx_r;
  assign mul_b   = coef_b * sy_r;
  assign row_sum = AW'(prod_a) + AW'(prod_b) + addend;

  assign den_abs = den_acc[AW-1] ? AW'(-den_acc) : AW'(den_acc);
  assign nx_abs  = nx_acc[AW-1]  ? AW'(-nx_acc)  : AW'(nx_acc);
  assign ny_abs  = ny_acc[AW-1]  ? AW'(-ny_acc)  : AW'(ny_acc);

  hic_divider u_div_x (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .num      (nx_abs[GW-1:0]),
    .den      (den_abs[GW-1:0]),
    .quot_mag (qx)
  );

  hic_divider u_div_y (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .num      (ny_abs[GW-1:0]),
    .den      (den_abs[GW-1:0]),
    .quot_mag (qy)
  );

  assign dx  = DW'(px_r) - DW'(dstx_r);
  assign dy  = DW'(py_r) - DW'(dsty_r);
  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

  assign ssum = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign inl       = !degen_r && (sq_r <= {{(EW-2*TW){1'b0}}, thr2_r});
  assign total     = {1'b0, running} + {{NW{1'b0}}, inl};
  assign total_cap = (total > {1'b0, CNT_CAP}) ? CNT_CAP : total[NW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r   <= src_x;
      sy_r   <= src_y;
      dstx_r <= dst_x;
      dsty_r <= dst_y;
      last_r <= last_point;
    end
    if (cmd.mul) begin
      prod_a <= mul_a;
      prod_b <= mul_b;
      prow   <= cmd.mul_row;
    end
    if (pvld) begin
      unique case (prow)
        hic_pkg::ROW_NX: nx_acc  <= row_sum;
        hic_pkg::ROW_NY: ny_acc  <= row_sum;
        default:         den_acc <= row_sum;
      endcase
    end
    if (cmd.div_start) begin
      degen_r <= status.w_zero;
      negx    <= nx_acc[AW-1] ^ den_acc[AW-1];
      negy    <= ny_acc[AW-1] ^ den_acc[AW-1];
    end
    if (cmd.round) begin
      px_r <= negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      py_r <= negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    if (cmd.diff) begin
      ax_r  <= adx[SW-1:0];
      ay_r  <= ady[SW-1:0];
      rng_r <= (adx[DW-1:SW] == '0) && (ady[DW-1:SW] == '0);
    end
    if (cmd.square) begin
      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      thr2_r <= coef.thr * coef.thr;
    end
    if (cmd.sum) begin
      sq_r <= (!rng_r || (ssum[2*SW:EW] != '0)) ? hic_pkg::ERR_MAX : ssum[EW-1:0];
    end
    if (cmd.emit) begin
      sq_error     <= degen_r ? hic_pkg::ERR_MAX : sq_r;
      inlier       <= inl;
      degenerate   <= degen_r;
      inlier_total <= total_cap;
      last_result  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld      <= 1'b0;
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      pvld <= cmd.mul;
      if (cmd.emit) begin
        running   <= last_r ? '0 : total_cap;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/hic_ctrl.sv =====
// Sequencer of the inlier test core: steps the datapath through one correspondence.
// Depends on hic_pkg.
module hic_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hic_pkg::status_t status,
  output hic_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL    = 10'b00_0000_0010,
    S_SUM    = 10'b00_0000_0100,
    S_DIVSET = 10'b00_0000_1000,
    S_DIV    = 10'b00_0001_0000,
    S_ROUND  = 10'b00_0010_0000,
    S_DIFF   = 10'b00_0100_0000,
    S_SQR    = 10'b00_1000_0000,
    S_SSUM   = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_t;

  localparam logic [hic_pkg::DCNT_W-1:0] DCNT_LAST = hic_pkg::DCNT_W'(hic_pkg::DIV_STEPS - 1);

  state_t                     state, state_next;
  hic_pkg::row_t              mrow, mrow_next;
  logic [hic_pkg::DCNT_W-1:0] dcnt, dcnt_next;

  always_comb begin
    state_next = state;
    mrow_next  = mrow;
    dcnt_next  = dcnt;
    cmd        = '0;
    cmd.mul_row = mrow;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          mrow_next  = hic_pkg::ROW_DEN;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        unique case (mrow)
          hic_pkg::ROW_DEN: mrow_next = hic_pkg::ROW_NX;
          hic_pkg::ROW_NX:  mrow_next = hic_pkg::ROW_NY;
          default:          state_next = S_SUM;
        endcase
      end
      S_SUM: state_next = S_DIVSET;
      S_DIVSET: begin
        cmd.div_start = 1'b1;
        dcnt_next     = '0;
        state_next    = status.w_zero ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + 1'b1;
        if (dcnt == DCNT_LAST) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_next = S_SSUM;
      end
      S_SSUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mrow  <= hic_pkg::ROW_DEN;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      mrow  <= mrow_next;
      dcnt  <= dcnt_next;
    end
  end

endmodule

// ===== hdl/hic_checker.sv =====
// Port-level checks of the inlier test core, bound to its top level.
// Depends on hic_pkg and homography_inlier_check_core_assert.svh.
`include "homography_inlier_check_core_assert.svh"

module hic_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [hic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [hic_pkg::CFG_DATA_W-1:0]    cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic signed [hic_pkg::PT_W-1:0]   src_x,
  input logic signed [hic_pkg::PT_W-1:0]   src_y,
  input logic signed [hic_pkg::PT_W-1:0]   dst_x,
  input logic signed [hic_pkg::PT_W-1:0]   dst_y,
  input logic                              last_point,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [hic_pkg::SQ_W-1:0]          sq_error,
  input logic                              inlier,
  input logic                              degenerate,
  input logic [hic_pkg::CNT_W-1:0]         inlier_total,
  input logic                              last_result
);

  `HIC_ASSERT_NR(a_reset_clears, rst |=> (!out_valid && !in_stall), "reset left a word or stall")
  `HIC_ASSERT(a_one_at_a_time, (in_valid && !in_stall) |=> in_stall, "second word taken while busy")
  `HIC_ASSERT(a_no_instant_result, (in_valid && !in_stall) |=> !$rose(out_valid), "result too early")
  `HIC_ASSERT(a_degenerate_word, (out_valid && degenerate) |-> (sq_error == hic_pkg::ERR_MAX && !inlier), "degenerate result not saturated")
  `HIC_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sq_error) && $stable(inlier_total)), "stalled result changed")

endmodule

bind homography_inlier_check_core hic_checker u_hic_checker (.*);

// ===== tb/homography_inlier_check_core_test.sv =====
// Self-checking test of homography_inlier_check_core: a predictor scores each point word
// against the current homography and threshold; a checker compares every result word.
// Depends on hic_pkg and the core RTL.
module homography_inlier_check_core_test;
  import hic_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_POINTS = 135;
  localparam int unsigned LONG_POINTS  = 120;
  localparam logic signed [PT_W-1:0] PT_MAX = 24'sh7FFFFF;
  localparam logic signed [PT_W-1:0] PT_MIN = 24'sh800000;
  localparam logic [COEF_W-1:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [COEF_W-1:0] C_MAX   = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] C_MIN   = 32'h8000_0000;

  typedef struct {
    logic [SQ_W-1:0]  sq;
    logic             inl;
    logic             degen;
    logic [CNT_W-1:0] total;
    logic             last;
  } verdict_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [PT_W-1:0]       src_x = '0;
  logic signed [PT_W-1:0]       src_y = '0;
  logic signed [PT_W-1:0]       dst_x = '0;
  logic signed [PT_W-1:0]       dst_y = '0;
  logic                         last_point = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [SQ_W-1:0]              sq_error;
  logic                         inlier;
  logic                         degenerate;
  logic [CNT_W-1:0]             inlier_total;
  logic                         last_result;

  coef_t       coefs;
  int unsigned inlier_run = 0;
  verdict_t    pending_verdicts[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  homography_inlier_check_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .src_x        (src_x),
    .src_y        (src_y),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sq_error     (sq_error),
    .inlier       (inlier),
    .degenerate   (degenerate),
    .inlier_total (inlier_total),
    .last_result  (last_result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Restoring division of magnitudes, one guard bit, then round half up; cap at 2^40.
  function automatic logic [63:0] quotient_q8(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    logic        sat;
    logic        inbit;
    rem = '0;
    q = '0;
    sat = 1'b0;
    for (int i = 72; i >= 0; i--) begin
      inbit = (i >= 15) ? num[i-15] : 1'b0;
      rem = {rem[62:0], inbit};
      if (!sat) begin
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
        if (q >= (64'd1 << 41)) sat = 1'b1;
      end else if (rem >= den) begin
        rem = rem - den;
      end
    end
    if (sat) return 64'd1 << 40;
    q = (q + 64'd1) >> 1;
    return (q > (64'd1 << 40)) ? (64'd1 << 40) : q;
  endfunction

  function automatic longint project_coord(input longint numer, input longint den);
    logic [63:0] m;
    m = quotient_q8(magnitude(numer), magnitude(den));
    return ((numer < 0) != (den < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void project_point(input logic signed [PT_W-1:0] sx,
                                        input logic signed [PT_W-1:0] sy,
                                        output longint px, output longint py,
                                        output logic degen);
    longint x;
    longint y;
    longint w;
    longint nx;
    longint ny;
    x = sx;
    y = sy;
    w = longint'($signed(coefs.h20)) * x + longint'($signed(coefs.h21)) * y
        + (longint'(1) << DEN_SHIFT);
    nx = longint'($signed(coefs.h00)) * x + longint'($signed(coefs.h01)) * y
         + longint'($signed(coefs.h02)) * 65536;
    ny = longint'($signed(coefs.h10)) * x + longint'($signed(coefs.h11)) * y
         + longint'($signed(coefs.h12)) * 65536;
    degen = (w == 0);
    px = 0;
    py = 0;
    if (!degen) begin
      px = project_coord(nx, w);
      py = project_coord(ny, w);
    end
  endfunction

  function automatic verdict_t score_point(input logic signed [PT_W-1:0] sx,
                                           input logic signed [PT_W-1:0] sy,
                                           input logic signed [PT_W-1:0] tx,
                                           input logic signed [PT_W-1:0] ty,
                                           input logic last);
    longint      px;
    longint      py;
    logic        degen;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] s;
    verdict_t    v;
    project_point(sx, sy, px, py, degen);
    v.sq = ERR_MAX;
    v.inl = 1'b0;
    v.degen = degen;
    v.total = '0;
    v.last = last;
    if (!degen) begin
      ax = magnitude(px - longint'(tx));
      ay = magnitude(py - longint'(ty));
      if (ax < (64'd1 << SQ_IN_W) && ay < (64'd1 << SQ_IN_W)) begin
        s = ax * ax + ay * ay;
        if (s <= 64'(ERR_MAX)) v.sq = s[SQ_W-1:0];
      end
      v.inl = (64'(v.sq) <= 64'(coefs.thr) * 64'(coefs.thr));
    end
    return v;
  endfunction

  function automatic int spread(input int unsigned r);
    return int'($urandom_range(0, 2 * r)) - int'(r);
  endfunction

  function automatic logic signed [PT_W-1:0] rand_coord();
    return PT_W'($urandom);
  endfunction

  function automatic int unsigned idle_gap();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 70);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
  endfunction

  task automatic send_point(input logic signed [PT_W-1:0] sx, input logic signed [PT_W-1:0] sy,
                            input logic signed [PT_W-1:0] tx, input logic signed [PT_W-1:0] ty,
                            input logic last);
    verdict_t    v;
    int unsigned gap;
    int unsigned sum;
    gap = idle_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_x = sx;
    src_y = sy;
    dst_x = tx;
    dst_y = ty;
    last_point = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    v = score_point(sx, sy, tx, ty, last);
    sum = inlier_run + v.inl;
    if (sum > CNT_CAP) sum = CNT_CAP;
    v.total = sum[CNT_W-1:0];
    inlier_run = last ? 0 : sum;
    pending_verdicts.push_back(v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_H00:   coefs.h00 = data[COEF_W-1:0];
      REG_H01:   coefs.h01 = data[COEF_W-1:0];
      REG_H02:   coefs.h02 = data[COEF_W-1:0];
      REG_H10:   coefs.h10 = data[COEF_W-1:0];
      REG_H11:   coefs.h11 = data[COEF_W-1:0];
      REG_H12:   coefs.h12 = data[COEF_W-1:0];
      REG_PERSP: {coefs.h20, coefs.h21} = data;
      REG_THR:   coefs.thr = data[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper data bits of the narrow registers carry junk that must be dropped.
  task automatic load_homography(input logic [COEF_W-1:0] h00, input logic [COEF_W-1:0] h01,
                                 input logic [COEF_W-1:0] h02, input logic [COEF_W-1:0] h10,
                                 input logic [COEF_W-1:0] h11, input logic [COEF_W-1:0] h12,
                                 input logic [COEF_W-1:0] h20, input logic [COEF_W-1:0] h21,
                                 input logic [THR_W-1:0] thr);
    drain_results();
    write_reg(REG_H00, {32'($urandom), h00});
    write_reg(REG_H01, {32'($urandom), h01});
    write_reg(REG_H02, {32'($urandom), h02});
    write_reg(REG_H10, {32'($urandom), h10});
    write_reg(REG_H11, {32'($urandom), h11});
    write_reg(REG_H12, {32'($urandom), h12});
    write_reg(REG_PERSP, {h20, h21});
    write_reg(REG_THR, {32'($urandom), 16'($urandom), thr});
  endtask

  task automatic test_identity_defaults();
    send_point(0, 0, 0, 0, 0);
    send_point(24'sd256, 24'sd512, 24'sd1024, 24'sd512, 0);
    send_point(24'sd256, 24'sd512, 24'sd1025, 24'sd512, 0);
    send_point(PT_MAX, PT_MAX, PT_MAX, PT_MAX, 0);
    send_point(PT_MIN, PT_MIN, PT_MIN, PT_MIN, 0);
    send_point(PT_MAX, PT_MIN, PT_MIN, PT_MAX, 0);
    send_point(PT_MAX, 0, PT_MIN, 0, 1);
    send_point(-24'sd100, 24'sd100, -24'sd100, 24'sd100, 1);
    drain_results();
  endtask

  task automatic test_threshold_edges();
    load_homography(ONE_Q24, 0, 0, 0, ONE_Q24, 0, 0, 0, 16'h0000);
    send_point(24'sd300, -24'sd300, 24'sd300, -24'sd300, 0);
    send_point(24'sd300, -24'sd300, 24'sd301, -24'sd300, 0);
    load_homography(ONE_Q24, 0, 0, 0, ONE_Q24, 0, 0, 0, 16'hFFFF);
    send_point(0, 0, 24'sd60000, 0, 0);
    send_point(0, 0, 24'sd65535, 0, 0);
    send_point(0, 0, 24'sd65535, 24'sd1, 0);
    load_homography(C_MAX, 0, 0, 0, ONE_Q24, 0, 0, 0, 16'hFFFF);
    send_point(24'sh400000, 0, 0, 0, 1);
    drain_results();
  endtask

  task automatic test_zero_denominator();
    load_homography(C_MAX, 0, 0, 0, ONE_Q24, 0, 32'hC000_0001, 32'hC000_0000, 16'd768);
    send_point(24'sd256, 0, 0, 0, 0);
    send_point(0, 24'sd256, 0, 0, 0);
    send_point(24'sd256, 24'sd256, 24'sd5, 24'sd5, 0);
    send_point(-24'sd256, 0, 0, 0, 0);
    send_point(0, 24'sd256, 24'sd1, 24'sd1, 1);
    load_homography(ONE_Q24, 0, 0, 0, ONE_Q24, 0, 32'hC000_0000, 0, 16'd768);
    send_point(0, 0, 0, 0, 0);
    send_point(24'sd256, 24'sd1234, 0, 0, 0);
    send_point(24'sd256, -24'sd77, 0, 0, 1);
    drain_results();
  endtask

  task automatic test_unused_index();
    logic signed [PT_W-1:0] c;
    drain_results();
    for (int idx = 8; idx < 16; idx++) write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
    for (int n = 0; n < 4; n++) begin
      c = rand_coord();
      send_point(c, -c, c, rand_coord(), n == 3);
    end
    drain_results();
  endtask

  // Send one long set of inliers with no gaps and no output stalls.
  task automatic test_long_set();
    logic signed [PT_W-1:0] a;
    logic signed [PT_W-1:0] b;
    load_homography(ONE_Q24, 0, 0, 0, ONE_Q24, 0, 0, 0, 16'd768);
    calm = 1'b1;
    for (int n = 0; n < LONG_POINTS; n++) begin
      a = rand_coord();
      b = rand_coord();
      send_point(a, b, a, b, n == LONG_POINTS - 1);
    end
    send_point(0, 0, 0, 0, 0);
    drain_results();
    calm = 1'b0;
  endtask

  task automatic test_random_homographies();
    longint                 px;
    longint                 py;
    logic                   degen;
    logic signed [PT_W-1:0] sx;
    logic signed [PT_W-1:0] sy;
    int unsigned            r;
    logic                   lastp;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0)
        load_homography(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 16'hFFFF);
      else if (phase == 1)
        load_homography(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 16'h0000);
      else if (phase == PHASES - 1)
        load_homography($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, 16'($urandom));
      else
        load_homography(32'(2 ** 24 + spread(1 << 20)), 32'(spread(1 << 20)),
                        32'(spread(1 << 24)), 32'(spread(1 << 20)),
                        32'(2 ** 24 + spread(1 << 20)), 32'(spread(1 << 24)),
                        32'(spread(1 << 14)), 32'(spread(1 << 14)),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                                                      16'($urandom_range(0, 2048)));
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (n == PHASE_POINTS / 2) drain_results();
        lastp = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 6) == 0) begin
          send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), lastp);
        end else begin
          sx = PT_W'(spread(1 << 20));
          sy = PT_W'(spread(1 << 20));
          project_point(sx, sy, px, py, degen);
          r = coefs.thr + coefs.thr / 2 + 1;
          send_point(sx, sy, PT_W'(px + spread(r)), PT_W'(py + spread(r)), lastp);
        end
      end
    end
    drain_results();
  endtask

  initial begin : output_backpressure
    int unsigned hold;
    int unsigned free;
    forever begin
      if (calm) begin
        @(negedge clk);
        out_stall = 1'b0;
      end else begin
        hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        free = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
        repeat (hold) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
        repeat (free) begin
          @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result word with nothing expected, sq_error %h", sq_error));
      end else begin
        want = pending_verdicts.pop_front();
        if (sq_error !== want.sq)
          report($sformatf("sq_error %h, want %h", sq_error, want.sq));
        if (inlier !== want.inl)
          report($sformatf("inlier %b, want %b", inlier, want.inl));
        if (degenerate !== want.degen)
          report($sformatf("degenerate %b, want %b", degenerate, want.degen));
        if (inlier_total !== want.total)
          report($sformatf("inlier_total %0d, want %0d", inlier_total, want.total));
        if (last_result !== want.last)
          report($sformatf("last_result %b, want %b", last_result, want.last));
      end
    end
  end

  initial begin
    coefs = '0;
    coefs.h00 = ONE_Q24;
    coefs.h11 = ONE_Q24;
    coefs.thr = 16'd768;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_identity_defaults();
    test_threshold_edges();
    test_zero_denominator();
    test_unused_index();
    test_long_set();
    test_random_homographies();
    drain_results();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hic_pkg.sv
hdl/hic_cfg_regs.sv
hdl/hic_divider.sv
hdl/hic_datapath.sv
hdl/hic_ctrl.sv
hdl/homography_inlier_check_core.sv
hdl/hic_checker.sv
tb/homography_inlier_check_core_test.sv
